>>> src/psa_pkg.sv
package psa_pkg;

    localparam int TABLE_DEPTH_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int PID_BITS_DEF      = 8;

    // Fixed widths of the request and result fields.
    localparam int FIELD_W     = 8;
    localparam int SLOT_OUT_W  = 4;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_TICK   = 1'b1
    } op_code_t;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_CHOSEN   = 2'd2,
        STATUS_IDLE     = 2'd3
    } status_code_t;

    typedef struct packed {
        logic capture;
        logic rd_cur;
        logic scan_clear;
        logic load_cur;
        logic scan_issue;
        logic wr_cand;
        logic finish_insert;
        logic finish_tick;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic scan_done;
    } stat_t;

endpackage

>>> src/psa_ctrl.sv
module psa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           op,
    output logic           in_ready,
    output psa_pkg::cmd_t  cmd,
    input  psa_pkg::stat_t stat
);
    import psa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INSERT = 7'b0000010,
        S_CUR    = 7'b0000100,
        S_LATCH  = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_UPD    = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (op == OP_TICK) ? S_CUR : S_INSERT;
                end
            end
            S_INSERT:
            begin
                if (stat.out_free)
                begin
                    cmd.finish_insert = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_CUR:
            begin
                cmd.rd_cur     = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = S_LATCH;
            end
            S_LATCH:
            begin
                cmd.load_cur   = 1'b1;
                cmd.scan_issue = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                // The last compare completes in the cycle that sees the scan done.
                cmd.scan_issue = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.wr_cand = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.finish_tick = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_tick_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_tick || cmd.finish_insert) |-> stat.out_free)
        else $error("result loaded while the output register is still occupied");

    a_update_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_cand |-> stat.scan_done)
        else $error("candidate write-back before the scan has finished");

endmodule

>>> src/psa_datapath.sv
module psa_datapath #(
    parameter int TABLE_DEPTH   = psa_pkg::TABLE_DEPTH_DEF,
    parameter int PRIORITY_BITS = psa_pkg::PRIORITY_BITS_DEF,
    parameter int PID_BITS      = psa_pkg::PID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  psa_pkg::cmd_t                   cmd,
    output psa_pkg::stat_t                  stat,
    input  logic                            task_awake,
    input  logic [psa_pkg::FIELD_W-1:0]     task_pid,
    input  logic [psa_pkg::FIELD_W-1:0]     task_priority,
    input  logic [psa_pkg::FIELD_W-1:0]     task_initial_priority,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [1:0]                      status,
    output logic [psa_pkg::SLOT_OUT_W-1:0]  chosen_slot,
    output logic [psa_pkg::FIELD_W-1:0]     chosen_pid,
    output logic [psa_pkg::FIELD_W-1:0]     chosen_priority,
    output logic                            preempted
);
    import psa_pkg::*;

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic                     active;
        logic [PID_BITS-1:0]      pid;
        logic [PRIORITY_BITS-1:0] prio;
        logic [PRIORITY_BITS-1:0] init;
    } entry_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    entry_t cur_reg;
    entry_t wr_data;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;

    logic                     in_active_reg;
    logic [PID_BITS-1:0]      in_pid_reg;
    logic [PRIORITY_BITS-1:0] in_prio_reg;
    logic [PRIORITY_BITS-1:0] in_init_reg;

    logic [CNT_W-1:0]         fill_count_reg;
    logic [CNT_W-1:0]         scan_idx_reg;
    logic                     run_valid_reg;
    logic [SLOT_W-1:0]        run_slot_reg;

    logic                     cmp_pend_reg;
    logic [SLOT_W-1:0]        cmp_idx_reg;
    logic                     found_reg;
    logic [PRIORITY_BITS-1:0] best_reg;
    logic [SLOT_W-1:0]        cand_slot_reg;
    logic [PID_BITS-1:0]      cand_pid_reg;
    logic [PRIORITY_BITS-1:0] cand_init_reg;

    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [SLOT_OUT_W-1:0]    chosen_slot_reg;
    logic [FIELD_W-1:0]       chosen_pid_reg;
    logic [FIELD_W-1:0]       chosen_priority_reg;
    logic                     preempted_reg;

    logic table_full;
    logic scan_done;
    logic issue;
    logic better;
    logic take;
    logic dec_cur;
    logic [PRIORITY_BITS-1:0] cur_aged;

    assign table_full = (fill_count_reg >= CNT_W'(TABLE_DEPTH));
    assign scan_done  = (scan_idx_reg == fill_count_reg);
    assign issue      = cmd.scan_issue && !scan_done;

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.scan_done = scan_done;

    // Every active slot that shares the running task's pid is passed over.
    assign better = cmp_pend_reg && rd_data_reg.active
                    && !(run_valid_reg && (rd_data_reg.pid == cur_reg.pid))
                    && (rd_data_reg.prio > best_reg);

    assign take     = found_reg && (!run_valid_reg || (cand_init_reg >= cur_reg.prio));
    assign dec_cur  = found_reg && !take && run_valid_reg && (cur_reg.prio != '0);
    assign cur_aged = dec_cur ? (cur_reg.prio - PRIORITY_BITS'(1)) : cur_reg.prio;

    assign rd_addr = cmd.rd_cur ? run_slot_reg : scan_idx_reg[SLOT_W-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.finish_insert && !table_full)
        begin
            wr_en          = 1'b1;
            wr_addr        = fill_count_reg[SLOT_W-1:0];
            wr_data.active = in_active_reg;
            wr_data.pid    = in_pid_reg;
            wr_data.prio   = in_prio_reg;
            wr_data.init   = in_init_reg;
        end
        else if (cmd.wr_cand && found_reg)
        begin
            wr_en          = 1'b1;
            wr_addr        = cand_slot_reg;
            wr_data.active = 1'b1;
            wr_data.pid    = cand_pid_reg;
            wr_data.prio   = cand_init_reg;
            wr_data.init   = cand_init_reg;
        end
        else if (cmd.finish_tick && dec_cur)
        begin
            wr_en        = 1'b1;
            wr_addr      = run_slot_reg;
            wr_data      = cur_reg;
            wr_data.prio = cur_aged;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_active_reg <= task_awake;
            in_pid_reg    <= PID_BITS'(task_pid);
            in_prio_reg   <= PRIORITY_BITS'(task_priority);
            in_init_reg   <= PRIORITY_BITS'(task_initial_priority);
        end
        if (cmd.load_cur)
        begin
            cur_reg <= rd_data_reg;
        end
        if (cmd.scan_clear)
        begin
            scan_idx_reg <= '0;
            best_reg     <= '0;
        end
        else if (issue)
        begin
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
        end
        if (issue)
        begin
            cmp_idx_reg <= scan_idx_reg[SLOT_W-1:0];
        end
        if (better && !cmd.scan_clear)
        begin
            best_reg      <= rd_data_reg.prio;
            cand_slot_reg <= cmp_idx_reg;
            cand_pid_reg  <= rd_data_reg.pid;
            cand_init_reg <= rd_data_reg.init;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            run_valid_reg  <= 1'b0;
            run_slot_reg   <= '0;
            cmp_pend_reg   <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            cmp_pend_reg <= issue;
            if (cmd.scan_clear)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.finish_insert && !table_full)
            begin
                fill_count_reg <= fill_count_reg + CNT_W'(1);
            end
            if (cmd.finish_tick && take)
            begin
                run_valid_reg <= 1'b1;
                run_slot_reg  <= cand_slot_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish_insert || cmd.finish_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_insert)
        begin
            if (table_full)
            begin
                status_reg          <= STATUS_FULL;
                chosen_slot_reg     <= '0;
                chosen_pid_reg      <= '0;
                chosen_priority_reg <= '0;
            end
            else
            begin
                status_reg          <= STATUS_INSERTED;
                chosen_slot_reg     <= SLOT_OUT_W'(fill_count_reg[SLOT_W-1:0]);
                chosen_pid_reg      <= FIELD_W'(in_pid_reg);
                chosen_priority_reg <= FIELD_W'(in_prio_reg);
            end
            preempted_reg <= 1'b0;
        end
        else if (cmd.finish_tick)
        begin
            if (take)
            begin
                status_reg          <= STATUS_CHOSEN;
                chosen_slot_reg     <= SLOT_OUT_W'(cand_slot_reg);
                chosen_pid_reg      <= FIELD_W'(cand_pid_reg);
                chosen_priority_reg <= FIELD_W'(cand_init_reg);
                preempted_reg       <= 1'b1;
            end
            else if (run_valid_reg)
            begin
                status_reg          <= STATUS_CHOSEN;
                chosen_slot_reg     <= SLOT_OUT_W'(run_slot_reg);
                chosen_pid_reg      <= FIELD_W'(cur_reg.pid);
                chosen_priority_reg <= FIELD_W'(cur_aged);
                preempted_reg       <= 1'b0;
            end
            else
            begin
                status_reg          <= STATUS_IDLE;
                chosen_slot_reg     <= '0;
                chosen_pid_reg      <= '0;
                chosen_priority_reg <= '0;
                preempted_reg       <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign chosen_slot     = chosen_slot_reg;
    assign chosen_pid      = chosen_pid_reg;
    assign chosen_priority = chosen_priority_reg;
    assign preempted       = preempted_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_running_slot_filled: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (CNT_W'(run_slot_reg) < fill_count_reg))
        else $error("running slot points past the filled part of the table");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_reg != '0))
        else $error("candidate recorded with zero priority");

endmodule

>>> src/priority_scheduler_with_aging.sv
// Priority scheduler with aging.
// Requests arrive on the input channel (in_valid/in_ready) and each one yields
// exactly one result on the output channel (out_valid/out_ready).
// An insert request appends a task to the next free table slot, or reports a
// full table; its result is loaded into the output register from S_INSERT once
// that register is free, in the same cycle as the next request can be taken.
// A schedule tick first reads the running task's entry, then walks the filled
// slots one per cycle through the single read port of the task memory, then
// writes back the candidate's reloaded priority and, when the running task is
// kept, its aged priority. Its result is loaded from S_RESULT in the same way.
// Only one request is in progress at a time; a new request is taken while the
// previous result still waits in the output register.
// If the receiver stalls, the finished result is held in the output register
// and the block waits before loading the next one.
// Reset empties the table and leaves no task running; it needs no clearing pass.
module priority_scheduler_with_aging #(
    parameter int TABLE_DEPTH   = psa_pkg::TABLE_DEPTH_DEF,
    parameter int PRIORITY_BITS = psa_pkg::PRIORITY_BITS_DEF,
    parameter int PID_BITS      = psa_pkg::PID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic                            task_awake,
    input  logic [psa_pkg::FIELD_W-1:0]     task_pid,
    input  logic [psa_pkg::FIELD_W-1:0]     task_priority,
    input  logic [psa_pkg::FIELD_W-1:0]     task_initial_priority,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [psa_pkg::SLOT_OUT_W-1:0]  chosen_slot,
    output logic [psa_pkg::FIELD_W-1:0]     chosen_pid,
    output logic [psa_pkg::FIELD_W-1:0]     chosen_priority,
    output logic                            preempted
);
    import psa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    psa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    psa_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PID_BITS      (PID_BITS)
    ) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .stat                  (stat),
        .task_awake            (task_awake),
        .task_pid              (task_pid),
        .task_priority         (task_priority),
        .task_initial_priority (task_initial_priority),
        .out_ready             (out_ready),
        .out_valid             (out_valid),
        .status                (status),
        .chosen_slot           (chosen_slot),
        .chosen_pid            (chosen_pid),
        .chosen_priority       (chosen_priority),
        .preempted             (preempted)
    );

endmodule
